### sv/grayscale_dilation_3x3_macros.svh
// Assertion macros for the grayscale 3x3 dilation block.
// Used by the port checker; no other dependencies.
`ifndef GRAYSCALE_DILATION_3X3_MACROS_SVH
`define GRAYSCALE_DILATION_3X3_MACROS_SVH

// same-cycle implication, disabled during reset
`define GD3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GD3_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always checked
`define GD3_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/gd3_pkg.sv
// Shared constants, types and helpers for the grayscale 3x3 dilation block.
// No dependencies.
package gd3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_PASSES = 4;

   localparam int PIX_W  = 8;
   localparam int WID_W  = 12;
   localparam int HGT_W  = 16;
   localparam int PASS_W = 3;
   localparam int ROW_W  = HGT_W + 1;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int EW_W   = $clog2(MAX_WIDTH + 1);
   localparam int CW_W   = (EW_W > WID_W) ? EW_W : WID_W;
   localparam int PE_W   = $clog2(MAX_PASSES + 1) > PASS_W ? $clog2(MAX_PASSES + 1) : PASS_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [WID_W-1:0]  DEF_WIDTH  = WID_W'(640);
   localparam logic [HGT_W-1:0]  DEF_HEIGHT = HGT_W'(480);
   localparam logic [PASS_W-1:0] DEF_PASSES = '0;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_PASSES       = 2'd2
   } csr_index_type;

   // per-stage control handed from the address step to the window step
   typedef struct packed {
      logic             pass;
      logic             flush;
      logic             emit;
      logic             col0;
      logic             col2;
      logic             top_en;
      logic             mid_en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } stage_ctl_type;

   function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

### sv/grayscale_dilation_3x3.sv
// Top level of the streaming grayscale 3x3 dilation block.
// Depends on gd3_pkg.
//
// Usage:
//   req_*  : input items. req_action = 0 carries a pixel in raster order,
//            req_action = 1 is a flush tick. After the last pixel of a frame send
//            passes * (frame_width + 1) flush items to drain the active stages.
//   rsp_*  : dilated pixels in raster order; rsp_frame_end marks the last pixel.
//   csr_*  : register writes (0 frame_width, 1 frame_height, 2 passes). A write
//            restarts the pipeline; write only while the block is idle.
// Throughput: one item per cycle while the result queue is not full. Every stage
//   is two register steps: a line buffer read with counter update, then the window
//   max and line buffer write. Every item crosses all MAX_PASSES stages whatever
//   passes is; inactive stages pass items.
// Stall: a two-entry result queue sits at the output. The pipeline freezes only
//   when both entries are held, and req_ready falls with it.
// Reset: registers return to 640 x 480, zero passes; pipeline and queue empty.
//   Line buffers need no clearing: reads of rows not yet written are masked off.
module grayscale_dilation_3x3
   import gd3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [WID_W-1:0]  frame_width_ff;
   logic [HGT_W-1:0]  frame_height_ff;
   logic [PASS_W-1:0] passes_ff;

   logic [CW_W-1:0]  w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [PE_W-1:0]  p_eff;
   logic             wide2;
   logic             cfg_clr;
   logic             en;

   // stage inputs; index MAX_PASSES is the chain output
   logic             in_v_ff [MAX_PASSES+1];
   logic             in_f_ff [MAX_PASSES+1];
   logic [PIX_W-1:0] in_d_ff [MAX_PASSES+1];

   // result queue
   logic [PIX_W-1:0] q_d_ff [2];
   logic             q_e_ff [2];
   logic             q_wp_ff, q_rp_ff;
   logic [1:0]       q_cnt_ff;
   logic [COL_W-1:0] ocol_ff;
   logic [HGT_W-1:0] orow_ff;
   logic             enq, deq, last_pix;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_clr = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_PASSES: cfg_clr = 1'b1;
            default: cfg_clr = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DEF_WIDTH;
         frame_height_ff <= DEF_HEIGHT;
         passes_ff       <= DEF_PASSES;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[WID_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[HGT_W-1:0];
            CSR_PASSES:       passes_ff       <= csr_data[PASS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0)
         w_eff = CW_W'(1);
      else if (CW_W'(frame_width_ff) > CW_W'(MAX_WIDTH))
         w_eff = CW_W'(MAX_WIDTH);
      else
         w_eff = CW_W'(frame_width_ff);
      h_eff = (frame_height_ff == '0) ? HGT_W'(1) : frame_height_ff;
      p_eff = (PE_W'(passes_ff) > PE_W'(MAX_PASSES)) ? PE_W'(MAX_PASSES)
                                                       : PE_W'(passes_ff);
      wide2 = (w_eff >= CW_W'(2));
   end

   assign en        = (q_cnt_ff != 2'd2);
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset || cfg_clr) begin
         in_v_ff[0] <= 1'b0;
      end else if (en) begin
         in_v_ff[0] <= req_valid;
      end
      if (en) begin
         in_f_ff[0] <= req_action;
         in_d_ff[0] <= req_pixel_in;
      end
   end

   for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
      logic [ROW_W-1:0]     row_ff;
      logic [COL_W-1:0]     col_ff;
      logic [ROW_W-1:0]     row_in;
      logic [COL_W-1:0]     col_in;
      logic                 bv_ff;
      stage_ctl_type        ctl_ff;
      stage_ctl_type        ctl_in;
      logic [2*PIX_W-1:0]   rd_ff;
      logic                 fwd_ff;
      logic [2*PIX_W-1:0]   fwd_d_ff;
      logic [PIX_W-1:0]     cm1_ff, cm2_ff;
      logic [2*PIX_W-1:0]   mem [MAX_WIDTH];

      logic                 active, lt_h, at_start, proc_a, pass_a, last_out, wrap;
      logic [CW_W:0]        col_inc;
      logic                 proc_b, fwd_in;
      logic [2*PIX_W-1:0]   pair, wr_d;
      logic [PIX_W-1:0]     top, mid, ncm, res;

      always_comb begin
         active   = (p_eff > PE_W'(s));
         lt_h     = (row_ff < ROW_W'(h_eff));
         at_start = (row_ff == '0) && (col_ff == '0);
         proc_a   = in_v_ff[s] && active && !(lt_h && in_f_ff[s] == ACT_FLUSH);
         pass_a   = in_v_ff[s] && (!active ||
                    (lt_h && in_f_ff[s] == ACT_FLUSH && at_start));
         last_out = (row_ff == ROW_W'(h_eff) + ROW_W'(1)) && (col_ff == '0);
         col_inc  = (CW_W+1)'(col_ff) + (CW_W+1)'(1);
         wrap     = (col_inc >= (CW_W+1)'(w_eff));
         if (last_out) begin
            row_in = '0;
            col_in = '0;
         end else if (wrap) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            row_in = row_ff;
            col_in = col_inc[COL_W-1:0];
         end
         ctl_in.pass   = pass_a;
         ctl_in.flush  = in_f_ff[s];
         ctl_in.emit   = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
         ctl_in.col0   = (col_ff == '0);
         ctl_in.col2   = (col_ff >= COL_W'(2));
         ctl_in.top_en = (row_ff >= ROW_W'(2));
         ctl_in.mid_en = (row_ff != '0);
         ctl_in.addr   = col_ff;
         ctl_in.data   = (pass_a || lt_h) ? in_d_ff[s] : '0;
      end

      always_comb begin
         proc_b = bv_ff && !ctl_ff.pass;
         fwd_in = proc_b && proc_a && (ctl_ff.addr == col_ff);
         pair   = fwd_ff ? fwd_d_ff : rd_ff;
         top    = ctl_ff.top_en ? pair[2*PIX_W-1:PIX_W] : '0;
         mid    = ctl_ff.mid_en ? pair[PIX_W-1:0] : '0;
         ncm    = max8(max8(top, mid), ctl_ff.data);
         wr_d   = {pair[PIX_W-1:0], ctl_ff.data};
         if (ctl_ff.col0)
            res = wide2 ? max8(cm2_ff, cm1_ff) : cm2_ff;
         else if (ctl_ff.col2)
            res = max8(max8(cm2_ff, ncm), cm1_ff);
         else
            res = max8(cm2_ff, ncm);
      end

      always_ff @(posedge clock) begin
         if (reset || cfg_clr) begin
            row_ff        <= '0;
            col_ff        <= '0;
            bv_ff         <= 1'b0;
            in_v_ff[s+1]  <= 1'b0;
         end else if (en) begin
            if (proc_a) begin
               row_ff <= row_in;
               col_ff <= col_in;
            end
            bv_ff        <= proc_a || pass_a;
            in_v_ff[s+1] <= bv_ff && (ctl_ff.pass || ctl_ff.emit);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff   <= ctl_in;
            fwd_ff   <= fwd_in;
            fwd_d_ff <= wr_d;
            if (proc_a)
               rd_ff <= mem[col_ff];
            if (proc_b) begin
               mem[ctl_ff.addr] <= wr_d;
               cm1_ff           <= cm2_ff;
               cm2_ff           <= ncm;
            end
            in_f_ff[s+1] <= ctl_ff.pass ? ctl_ff.flush : ACT_PIXEL;
            in_d_ff[s+1] <= ctl_ff.pass ? ctl_ff.data : res;
         end
      end
   end

   assign enq      = en && in_v_ff[MAX_PASSES] && (in_f_ff[MAX_PASSES] == ACT_PIXEL);
   assign deq      = rsp_valid && rsp_ready;
   assign last_pix = (CW_W'(ocol_ff) == w_eff - CW_W'(1)) &&
                     (orow_ff == h_eff - HGT_W'(1));

   always_ff @(posedge clock) begin
      if (reset || cfg_clr) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= '0;
         ocol_ff  <= '0;
         orow_ff  <= '0;
      end else begin
         if (enq) begin
            q_wp_ff <= ~q_wp_ff;
            if (last_pix) begin
               ocol_ff <= '0;
               orow_ff <= '0;
            end else if (CW_W'(ocol_ff) == w_eff - CW_W'(1)) begin
               ocol_ff <= '0;
               orow_ff <= orow_ff + HGT_W'(1);
            end else begin
               ocol_ff <= ocol_ff + COL_W'(1);
            end
         end
         if (deq)
            q_rp_ff <= ~q_rp_ff;
         unique case ({enq, deq})
            2'b10:   q_cnt_ff <= q_cnt_ff + 2'd1;
            2'b01:   q_cnt_ff <= q_cnt_ff - 2'd1;
            default: q_cnt_ff <= q_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_d_ff[q_wp_ff] <= in_d_ff[MAX_PASSES];
         q_e_ff[q_wp_ff] <= last_pix;
      end
   end

   assign rsp_valid     = (q_cnt_ff != '0);
   assign rsp_pixel_out = q_d_ff[q_rp_ff];
   assign rsp_frame_end = q_e_ff[q_rp_ff];

endmodule

### sv/gd3_checker.sv
// Port-level checker for the grayscale 3x3 dilation block, with its bind.
// Depends on gd3_pkg and grayscale_dilation_3x3_macros.svh.
`include "grayscale_dilation_3x3_macros.svh"

module gd3_checker
   import gd3_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIX_W-1:0]      rsp_pixel_out,
   input logic                  rsp_frame_end,
   input logic                  csr_valid,
   input logic [CSR_IDX_W-1:0]  csr_index
);

   `GD3_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready && !csr_valid, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_frame_end), "result changed while stalled")

   `GD3_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_valid && req_ready, "not empty after reset")

   `GD3_ASSERT_NXT(a_cfg_flush, clock, reset, csr_valid && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT || csr_index == CSR_PASSES), !rsp_valid && req_ready, "results survive a register write")

   `GD3_ASSERT_IMP(a_stall_full, clock, reset, !req_ready, rsp_valid, "input stalled with no result pending")

endmodule

bind grayscale_dilation_3x3 gd3_checker u_gd3_checker (.*);

### tb/tb_grayscale_dilation_3x3.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming grayscale 3x3 dilation block.
// Predicts every dilated pixel in a scoreboard class; depends on gd3_pkg and the RTL.
module tb_grayscale_dilation_3x3;
   import gd3_pkg::*;

   localparam int unsigned SETTLE         = 2 * MAX_PASSES + 6;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned RANDOM_ITEMS   = 1000;

   typedef enum logic [1:0] {TOK_NONE, TOK_PIXEL, TOK_FLUSH} token_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } dilated_type;

   class dilation_board_type;
      logic [WID_W-1:0]      width_reg;
      logic [HGT_W-1:0]      height_reg;
      logic [PASS_W-1:0]     passes_reg;
      logic [PIX_W-1:0]      line_mem [MAX_PASSES][2][MAX_WIDTH];
      logic [2:0][PIX_W-1:0] win [MAX_PASSES][3];
      int unsigned           col_pos [MAX_PASSES];
      int unsigned           row_pos [MAX_PASSES];
      int unsigned           out_count;
      dilated_type           dilated_q [$];
      int unsigned           failures;

      function new();
         width_reg  = DEF_WIDTH;
         height_reg = DEF_HEIGHT;
         passes_reg = DEF_PASSES;
         failures   = 0;
         restart();
      endfunction

      function void restart();
         foreach (line_mem[s, r, c]) line_mem[s][r][c] = '0;
         foreach (win[s, k]) win[s][k] = '0;
         foreach (col_pos[s]) begin
            col_pos[s] = 0;
            row_pos[s] = 0;
         end
         out_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_FRAME_WIDTH: begin
               width_reg = val[WID_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_reg = val[HGT_W-1:0];
            end
            CSR_PASSES: begin
               passes_reg = val[PASS_W-1:0];
            end
            default: begin
               return;
            end
         endcase
         restart();
      endfunction

      function int unsigned eff_w();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_h();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function int unsigned eff_p();
         return (passes_reg > MAX_PASSES) ? MAX_PASSES : passes_reg;
      endfunction

      function logic [PIX_W-1:0] brighter(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
         return (a > b) ? a : b;
      endfunction

      function logic [PIX_W-1:0] column_peak(logic [2:0][PIX_W-1:0] c);
         return brighter(brighter(c[0], c[1]), c[2]);
      endfunction

      // one dilation stage; returns what it hands to the next stage
      function token_type dilate_stage(int unsigned s, token_type kind,
                                       inout logic [PIX_W-1:0] v);
         int unsigned      w, h, row, col;
         logic [PIX_W-1:0] b, top, mid, peak;
         bit               emit;
         w = eff_w();
         h = eff_h();
         row = row_pos[s];
         col = col_pos[s];
         peak = '0;
         if (kind == TOK_NONE) return TOK_NONE;
         if (row < h) begin
            if (kind == TOK_FLUSH) return (row == 0 && col == 0) ? TOK_FLUSH : TOK_NONE;
            b = v;
         end else begin
            b = '0;
         end
         if (col >= MAX_WIDTH) col = 0;
         top = (row >= 2) ? line_mem[s][1][col] : '0;
         mid = (row >= 1) ? line_mem[s][0][col] : '0;
         line_mem[s][1][col] = line_mem[s][0][col];
         line_mem[s][0][col] = b;
         emit = (row >= 2) || (row == 1 && col >= 1);
         if (col == 0) begin
            peak = column_peak(win[s][2]);
            if (w >= 2) peak = brighter(peak, column_peak(win[s][1]));
         end
         win[s][0] = win[s][1];
         win[s][1] = win[s][2];
         win[s][2] = {b, mid, top};
         if (col >= 1) begin
            peak = brighter(column_peak(win[s][1]), column_peak(win[s][2]));
            if (col >= 2) peak = brighter(peak, column_peak(win[s][0]));
         end
         if (row == h + 1 && col == 0) begin
            row_pos[s] = 0;
            col_pos[s] = 0;
         end else begin
            col++;
            if (col >= w) begin
               col = 0;
               row++;
            end
            row_pos[s] = row;
            col_pos[s] = col;
         end
         if (!emit) return TOK_NONE;
         v = peak;
         return TOK_PIXEL;
      endfunction

      function void take_item(logic act, logic [PIX_W-1:0] pix);
         token_type        kind;
         logic [PIX_W-1:0] v;
         int unsigned      total;
         dilated_type      d;
         kind = (act == ACT_FLUSH) ? TOK_FLUSH : TOK_PIXEL;
         v = pix;
         for (int unsigned s = 0; s < eff_p(); s++) kind = dilate_stage(s, kind, v);
         if (kind != TOK_PIXEL) return;
         total = eff_w() * eff_h();
         d.pixel = v;
         d.frame_end = (out_count + 1 >= total);
         if (d.frame_end) out_count = 0;
         else out_count++;
         dilated_q = {dilated_q, d};
      endfunction

      function void check_dilated(logic [PIX_W-1:0] pix, logic fe);
         dilated_type d;
         if (dilated_q.size() == 0) begin
            $error("unexpected item: pixel_out %0d frame_end %0b", pix, fe);
            failures++;
            return;
         end
         d = dilated_q.pop_front();
         if (pix !== d.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", d.pixel, pix);
            failures++;
         end
         if (fe !== d.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", d.frame_end, fe);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return dilated_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_PIXEL;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   dilation_board_type board = new();
   int unsigned        idle_odds = 0;
   bit                 hold_request = 1'b0;
   int unsigned        items_sent = 0;

   always #5 clock = ~clock;

   grayscale_dilation_3x3 DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 4))
         0, 1: return '0;
         2: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic send(logic act, logic [PIX_W-1:0] pix);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.take_item(act, pix);
      items_sent++;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic settle_outputs(int unsigned extra);
      if (req_valid) req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_reg(idx, val);
   endtask

   // upper data bits are junk the block must mask off
   task automatic configure(logic [WID_W-1:0] w, logic [HGT_W-1:0] h, logic [PASS_W-1:0] p);
      settle_outputs(SETTLE);
      csr_write(CSR_FRAME_WIDTH, {(CSR_DATA_W-WID_W)'($urandom), w});
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_PASSES, {(CSR_DATA_W-PASS_W)'($urandom), p});
      csr_valid <= 1'b0;
   endtask

   // noisy frames get stray flushes, short or long drains, or pixels mixed into the drain
   task automatic run_frame(bit noisy);
      int unsigned w, h, p, n, drain, twist;
      w = board.eff_w();
      h = board.eff_h();
      p = board.eff_p();
      for (n = 0; n < w * h; n++) begin
         if (noisy && $urandom_range(0, 7) == 0) send(ACT_FLUSH, pick_pixel());
         send(ACT_PIXEL, pick_pixel());
      end
      drain = p * (w + 1);
      twist = noisy ? $urandom_range(1, 3) : 0;
      if (twist == 1) drain = $urandom_range(0, drain);
      else if (twist == 2) drain += $urandom_range(1, 4);
      for (n = 0; n < drain; n++)
         send((twist == 3 && $urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_FLUSH, pick_pixel());
   endtask

   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_dilated(rsp_pixel_out, rsp_frame_end);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [PIX_W-1:0] plate [9];
      int unsigned      random_base, n;
      plate = '{8'd0, 8'd0, 8'd7, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd1};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_odds = 3;
      configure(WID_W'(3), HGT_W'(3), PASS_W'(1));
      send(ACT_FLUSH, 8'hFF);
      for (n = 0; n < 9; n++) begin
         send(ACT_PIXEL, plate[n]);
         if (n == 4) send(ACT_FLUSH, 8'h00);
      end
      repeat (4) send(ACT_FLUSH, 8'h00);

      // width and height clamp to 1, passes to the stage count
      configure('0, '0, '1);
      send(ACT_PIXEL, 8'd200);
      send(ACT_PIXEL, 8'd17);
      repeat (7) send(ACT_FLUSH, 8'h5A);

      // output held off long enough to back up the input
      idle_odds = 0;
      configure(WID_W'(8), HGT_W'(6), PASS_W'(0));
      hold_request = 1'b1;
      run_frame(1'b0);

      // width above the line buffer size clamps, so no early frame end
      idle_odds = 4;
      configure('1, HGT_W'(1), PASS_W'(0));
      repeat (24) send(ACT_PIXEL, pick_pixel());
      configure(WID_W'(2), '1, PASS_W'(3));
      repeat (24) send(ACT_PIXEL, pick_pixel());

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if (items_sent - random_base > RANDOM_ITEMS - 300) idle_odds = 0;
         else idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         configure(WID_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(1, 16)),
                   HGT_W'($urandom_range(0, 5)), PASS_W'($urandom_range(0, 7)));
         repeat ($urandom_range(1, 3)) begin
            run_frame($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) settle_outputs(0);
         end
      end

      settle_outputs(SETTLE);
      if (board.failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
